// File: sv/plm_pkg.sv
package plm_pkg;

    // table geometry
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int OP_W       = 2;
    localparam int X_W        = 32;
    localparam int A_W        = 16;
    localparam int WORD_W     = X_W + A_W;

    // interpolation datapath
    localparam int PROD_W     = X_W + A_W;
    localparam int QUO_W      = A_W;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic signed [X_W-1:0]   t_x;
    typedef logic [A_W-1:0]          t_alpha;
    typedef logic [WORD_W-1:0]       t_word;

    localparam t_alpha ALPHA_ONE   = t_alpha'(32768);
    localparam t_count MIN_POINTS  = t_count'(2);
    localparam t_count COUNT_LIMIT = t_count'(MAX_POINTS);
    localparam t_count COUNT_RESET = t_count'(2);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_EVAL  = 2'd1,
        OP_CORE  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV_X0,
        S_EV_XN,
        S_EV_CHKN,
        S_EV_MID,
        S_EV_CMP,
        S_EV_LO,
        S_EV_HI,
        S_EV_DIFF,
        S_EV_MUL,
        S_EV_START,
        S_EV_WAIT,
        S_CORE_FWD,
        S_CORE_BWD,
        S_DONE
    } t_state;

    // divider status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: sv/plm_if.sv
interface plm_in_if;
    logic                 valid;
    logic                 ready;
    logic [plm_pkg::OP_W-1:0] operation;
    plm_pkg::t_addr       point_index;
    plm_pkg::t_x          point_x;
    plm_pkg::t_alpha      point_alpha;
    plm_pkg::t_x          query_x;

    modport source (
        output valid, operation, point_index, point_x, point_alpha, query_x,
        input  ready
    );
    modport sink (
        input  valid, operation, point_index, point_x, point_alpha, query_x,
        output ready
    );
endinterface

interface plm_out_if;
    logic            valid;
    logic            ready;
    plm_pkg::t_alpha membership;
    plm_pkg::t_x     core_lower;
    logic            core_lower_valid;
    plm_pkg::t_x     core_upper;
    logic            core_upper_valid;

    modport source (
        output valid, membership, core_lower, core_lower_valid, core_upper,
               core_upper_valid,
        input  ready
    );
    modport sink (
        input  valid, membership, core_lower, core_lower_valid, core_upper,
               core_upper_valid,
        output ready
    );
endinterface

// File: sv/piecewise_linear_membership.sv
// Piecewise-linear membership table: up to 64 breakpoints (x in signed Q16.16,
// membership in Q1.15) held in one single-port-read RAM, each item handled to
// completion before the next is taken. An evaluate item reads the two end
// points, then binary-searches the table with one RAM read a step, reads the
// enclosing pair, multiplies once and runs a 16-step shift-subtract divider.
// A core item streams the table through the RAM read port one entry a cycle,
// forward and then backward, stopping each pass at the first fall. Entries
// must be written before they are read, and point_count may only change while
// the block is idle. A finished result waits in an output register, so the
// next item can be taken while it is unread.
module piecewise_linear_membership (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [plm_pkg::CNT_W-1:0] i_cfg_wdata,
    plm_in_if.sink                   i_item,
    plm_out_if.source                o_result
);
    import plm_pkg::*;

    t_state         r_state, n_state;
    t_count         r_point_count;
    t_x             r_q, n_q;
    t_addr          r_lo, n_lo;
    t_addr          r_hi, n_hi;
    t_x             r_x0, n_x0;
    t_alpha         r_a0, n_a0;
    logic [X_W-1:0] r_t, n_t;
    logic [X_W-1:0] r_dx, n_dx;
    t_alpha         r_absda, n_absda;
    logic           r_neg, n_neg;
    logic [PROD_W-1:0] r_prod, n_prod;
    t_count         r_i, n_i;
    t_addr          r_j, n_j;
    logic           r_v, n_v;
    t_alpha         r_prev, n_prev;
    logic           r_found, n_found;

    // result being built and the output register
    t_alpha         r_res_mem, n_res_mem;
    t_x             r_res_lb, n_res_lb;
    logic           r_res_lv, n_res_lv;
    t_x             r_res_ub, n_res_ub;
    logic           r_res_uv, n_res_uv;
    t_alpha         r_out_mem;
    t_x             r_out_lb;
    logic           r_out_lv;
    t_x             r_out_ub;
    logic           r_out_uv;
    logic           r_out_valid, n_out_valid;
    logic           out_load;

    // memory ports
    logic           mem_we;
    t_word          mem_wdata;
    t_addr          mem_raddr;
    t_word          mem_rdata;
    t_x             rd_x;
    t_alpha         rd_a;

    // divider
    logic           div_start;
    logic [QUO_W-1:0] div_quo;
    t_div_stat      div_stat;

    // misc datapath
    t_count         used_n;
    t_addr          last_idx;
    t_addr          mid;
    logic           accept;
    logic signed [X_W:0]   dx_w;
    logic signed [X_W:0]   t_w;
    logic signed [A_W:0]   da_w;
    logic signed [A_W:0]   da_neg;
    logic signed [A_W+1:0] q_signed;
    logic signed [A_W+2:0] sum_w;
    t_alpha         a0_sat;

    plm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_item.point_index),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    plm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dx),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    // clamp the point count to the table range
    always_comb begin
        if (r_point_count < MIN_POINTS) begin
            used_n = MIN_POINTS;
        end else if (r_point_count > COUNT_LIMIT) begin
            used_n = COUNT_LIMIT;
        end else begin
            used_n = r_point_count;
        end
        last_idx = t_addr'(used_n - t_count'(1));
        mid      = t_addr'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    end

    assign accept    = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign mem_we    = accept && (i_item.operation == OP_WRITE);
    assign mem_wdata = {i_item.point_x, i_item.point_alpha};
    assign rd_x      = t_x'(mem_rdata[WORD_W-1:A_W]);
    assign rd_a      = mem_rdata[A_W-1:0];
    assign div_start = (r_state == S_EV_START);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    // interval arithmetic and final sum
    always_comb begin
        dx_w     = {rd_x[X_W-1], rd_x} - {r_x0[X_W-1], r_x0};
        t_w      = {r_q[X_W-1], r_q} - {r_x0[X_W-1], r_x0};
        da_w     = $signed({1'b0, rd_a}) - $signed({1'b0, r_a0});
        da_neg   = -da_w;
        a0_sat   = (r_a0 > ALPHA_ONE) ? ALPHA_ONE : r_a0;
        q_signed = r_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        sum_w    = $signed({3'b000, r_a0}) + {q_signed[A_W+1], q_signed};
    end

    // controller: next state, read address and datapath updates
    always_comb begin
        n_state   = r_state;
        n_q       = r_q;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_x0      = r_x0;
        n_a0      = r_a0;
        n_t       = r_t;
        n_dx      = r_dx;
        n_absda   = r_absda;
        n_neg     = r_neg;
        n_prod    = r_prod;
        n_i       = r_i;
        n_j       = r_j;
        n_v       = r_v;
        n_prev    = r_prev;
        n_found   = r_found;
        n_res_mem = r_res_mem;
        n_res_lb  = r_res_lb;
        n_res_lv  = r_res_lv;
        n_res_ub  = r_res_ub;
        n_res_uv  = r_res_uv;
        mem_raddr = r_lo;
        n_out_valid = r_out_valid && !o_result.ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_q       = i_item.query_x;
                    n_res_mem = '0;
                    n_res_lb  = '0;
                    n_res_lv  = 1'b0;
                    n_res_ub  = '0;
                    n_res_uv  = 1'b0;
                    n_i       = '0;
                    n_v       = 1'b0;
                    n_found   = 1'b0;
                    case (i_item.operation)
                        OP_EVAL: n_state = S_EV_X0;
                        OP_CORE: n_state = S_CORE_FWD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_EV_X0: begin
                mem_raddr = '0;
                n_state   = S_EV_XN;
            end
            S_EV_XN: begin
                // data is x of the first point
                mem_raddr = last_idx;
                n_state   = (r_q <= rd_x) ? S_DONE : S_EV_CHKN;
            end
            S_EV_CHKN: begin
                // data is x of the last point
                n_lo = '0;
                n_hi = last_idx;
                if (r_q >= rd_x) begin
                    n_state = S_DONE;
                end else if (last_idx > t_addr'(1)) begin
                    n_state = S_EV_MID;
                end else begin
                    n_state = S_EV_LO;
                end
            end
            S_EV_MID: begin
                mem_raddr = mid;
                n_state   = S_EV_CMP;
            end
            S_EV_CMP: begin
                if (r_q < rd_x) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid;
                end
                n_state = ((n_hi - n_lo) > t_addr'(1)) ? S_EV_MID : S_EV_LO;
            end
            S_EV_LO: begin
                mem_raddr = r_lo;
                n_state   = S_EV_HI;
            end
            S_EV_HI: begin
                mem_raddr = r_lo + t_addr'(1);
                n_x0      = rd_x;
                n_a0      = rd_a;
                n_state   = S_EV_DIFF;
            end
            S_EV_DIFF: begin
                // data is the upper point of the interval
                if (dx_w <= 0) begin
                    n_res_mem = a0_sat;
                    n_state   = S_DONE;
                end else begin
                    n_dx    = dx_w[X_W-1:0];
                    n_t     = t_w[X_W-1:0];
                    n_neg   = da_w[A_W];
                    n_absda = da_w[A_W] ? da_neg[A_W-1:0] : da_w[A_W-1:0];
                    n_state = S_EV_MUL;
                end
            end
            S_EV_MUL: begin
                n_prod  = r_t * r_absda;
                n_state = S_EV_START;
            end
            S_EV_START: begin
                n_state = S_EV_WAIT;
            end
            S_EV_WAIT: begin
                if (div_stat.done) begin
                    if (sum_w < 0) begin
                        n_res_mem = '0;
                    end else if (sum_w > $signed({3'b000, ALPHA_ONE})) begin
                        n_res_mem = ALPHA_ONE;
                    end else begin
                        n_res_mem = sum_w[A_W-1:0];
                    end
                    n_state = S_DONE;
                end
            end
            S_CORE_FWD: begin
                // stream entries upward; data belongs to entry r_j
                mem_raddr = r_i[ADDR_W-1:0];
                n_i       = r_i + t_count'(1);
                n_j       = r_i[ADDR_W-1:0];
                n_v       = 1'b1;
                if (r_v) begin
                    if (r_j != '0 && rd_a < r_prev) begin
                        // first fall ends the pass
                        n_res_lv = r_found;
                        n_i      = t_count'(last_idx);
                        n_v      = 1'b0;
                        n_found  = 1'b0;
                        n_state  = S_CORE_BWD;
                    end else begin
                        if (r_j != '0 && rd_a > r_prev) begin
                            n_res_lb = rd_x;
                            n_found  = 1'b1;
                        end
                        n_prev = rd_a;
                        if (r_j == last_idx) begin
                            // no fall: lower bound not valid
                            n_res_lb = '0;
                            n_res_lv = 1'b0;
                            n_i      = t_count'(last_idx);
                            n_v      = 1'b0;
                            n_found  = 1'b0;
                            n_state  = S_CORE_BWD;
                        end
                    end
                end
            end
            S_CORE_BWD: begin
                // stream entries downward; mirror of the forward pass
                mem_raddr = r_i[ADDR_W-1:0];
                n_i       = r_i - t_count'(1);
                n_j       = r_i[ADDR_W-1:0];
                n_v       = 1'b1;
                if (r_v) begin
                    if (r_j != last_idx && rd_a < r_prev) begin
                        n_res_uv = r_found;
                        n_state  = S_DONE;
                    end else begin
                        if (r_j != last_idx && rd_a > r_prev) begin
                            n_res_ub = rd_x;
                            n_found  = 1'b1;
                        end
                        n_prev = rd_a;
                        if (r_j == '0) begin
                            n_res_ub = '0;
                            n_res_uv = 1'b0;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= COUNT_RESET;
            r_out_valid   <= 1'b0;
            r_v           <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_v         <= n_v;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_x0      <= n_x0;
        r_a0      <= n_a0;
        r_t       <= n_t;
        r_dx      <= n_dx;
        r_absda   <= n_absda;
        r_neg     <= n_neg;
        r_prod    <= n_prod;
        r_i       <= n_i;
        r_j       <= n_j;
        r_prev    <= n_prev;
        r_found   <= n_found;
        r_res_mem <= n_res_mem;
        r_res_lb  <= n_res_lb;
        r_res_lv  <= n_res_lv;
        r_res_ub  <= n_res_ub;
        r_res_uv  <= n_res_uv;
        if (out_load) begin
            r_out_mem <= r_res_mem;
            r_out_lb  <= r_res_lb;
            r_out_lv  <= r_res_lv;
            r_out_ub  <= r_res_ub;
            r_out_uv  <= r_res_uv;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.membership       = r_out_mem;
    assign o_result.core_lower       = r_out_lb;
    assign o_result.core_lower_valid = r_out_lv;
    assign o_result.core_upper       = r_out_ub;
    assign o_result.core_upper_valid = r_out_uv;

    // divider is never restarted while a division is running
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // binary search keeps a non-empty bracket
    a_search_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_MID || r_state == S_EV_CMP) |-> (r_hi - r_lo) > t_addr'(1))
        else $error("search bracket collapsed");

    // an accepted item always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("item accepted without starting work");

    // membership output stays saturated
    a_membership_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_mem <= ALPHA_ONE)
        else $error("membership above one");

endmodule

// File: sv/plm_ram.sv
module plm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/plm_div.sv
module plm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [plm_pkg::PROD_W-1:0] i_dividend,
    input  logic [plm_pkg::X_W-1:0]    i_divisor,
    output logic [plm_pkg::QUO_W-1:0]  o_quotient,
    output plm_pkg::t_div_stat         o_stat
);
    import plm_pkg::*;

    logic [X_W-1:0]       r_rem;
    logic [X_W-1:0]       n_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [QUO_W-1:0]     n_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [X_W:0]         trial;
    logic                 q_bit;

    // one restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        q_bit = (trial >= {1'b0, i_divisor});
        if (q_bit) begin
            n_rem = X_W'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = trial[X_W-1:0];
        end
        n_quo = {r_quo[QUO_W-2:0], q_bit};
    end

    // the dividend is below divisor * 2^QUO_W, so QUO_W steps give the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:QUO_W];
            r_quo <= i_dividend[QUO_W-1:0];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: tb/sv/tb_piecewise_linear_membership.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_membership;
    import plm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int TAIL_CYCLES  = 200;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 600;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        t_alpha membership;
        t_x     core_lower;
        logic   core_lower_valid;
        t_x     core_upper;
        logic   core_upper_valid;
    } answer_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    plm_in_if  item_if ();
    plm_out_if result_if ();

    piecewise_linear_membership dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    // mirror of the breakpoint table and the count register
    t_x      bp_x     [MAX_POINTS];
    t_alpha  bp_alpha [MAX_POINTS];
    t_count  count_reg;

    answer_t awaited_answers [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      hold_end    = 0;
    int      stall_pct   = 0;
    int      idle_pct    = 0;
    int      items_sent  = 0;
    bit      offering    = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    // count below two acts as two, above the table size as the table size
    function automatic int active_points();
        if (count_reg < MIN_POINTS) begin
            return 2;
        end
        if (count_reg > COUNT_LIMIT) begin
            return MAX_POINTS;
        end
        return int'(count_reg);
    endfunction

    function automatic t_alpha clamp_membership(longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 32768) begin
            return ALPHA_ONE;
        end
        return t_alpha'(v);
    endfunction

    // binary search for the enclosing pair, then exact linear interpolation
    function automatic t_alpha interpolate(t_x q);
        int     n;
        int     lo;
        int     hi;
        int     mid;
        longint x0, x1, a0, a1, dx;
        n  = active_points();
        lo = 0;
        hi = n - 1;
        if (q <= bp_x[0] || q >= bp_x[n-1]) begin
            return '0;
        end
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (q < bp_x[mid]) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        x0 = longint'(bp_x[lo]);
        x1 = longint'(bp_x[lo+1]);
        a0 = longint'(bp_alpha[lo]);
        a1 = longint'(bp_alpha[lo+1]);
        dx = x1 - x0;
        if (dx <= 0) begin
            return clamp_membership(a0);
        end
        return clamp_membership(a0 + ((longint'(q) - x0) * (a1 - a0)) / dx);
    endfunction

    // forward scan: last rise before the first fall
    function automatic void lower_core(output t_x bound, output logic found);
        int n;
        n     = active_points();
        bound = '0;
        found = 1'b0;
        for (int i = 0; i + 1 < n; i++) begin
            if (bp_alpha[i+1] < bp_alpha[i]) begin
                if (!found) begin
                    bound = '0;
                end
                return;
            end
            if (bp_alpha[i+1] > bp_alpha[i]) begin
                bound = bp_x[i+1];
                found = 1'b1;
            end
        end
        bound = '0;
        found = 1'b0;
    endfunction

    // backward scan: mirror of the forward one
    function automatic void upper_core(output t_x bound, output logic found);
        int n;
        n     = active_points();
        bound = '0;
        found = 1'b0;
        for (int i = n - 1; i > 0; i--) begin
            if (bp_alpha[i-1] < bp_alpha[i]) begin
                if (!found) begin
                    bound = '0;
                end
                return;
            end
            if (bp_alpha[i-1] > bp_alpha[i]) begin
                bound = bp_x[i-1];
                found = 1'b1;
            end
        end
        bound = '0;
        found = 1'b0;
    endfunction

    function automatic answer_t table_answer(logic [OP_W-1:0] op, t_addr idx, t_x px,
                                             t_alpha pa, t_x qx);
        answer_t ans;
        ans = '0;
        case (op)
            OP_WRITE: begin
                bp_x[idx]     = px;
                bp_alpha[idx] = pa;
            end
            OP_EVAL: begin
                ans.membership = interpolate(qx);
            end
            OP_CORE: begin
                lower_core(ans.core_lower, ans.core_lower_valid);
                upper_core(ans.core_upper, ans.core_upper_valid);
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // query mostly inside an interval, some on or next to a breakpoint
    function automatic t_x pick_query(int n);
        int     pick;
        int     i;
        longint lo_x;
        longint span;
        pick = $urandom_range(99);
        if (pick < 55) begin
            i    = $urandom_range(n - 2, 0);
            lo_x = longint'(bp_x[i]);
            span = longint'(bp_x[i+1]) - lo_x;
            if (span > 1) begin
                return t_x'(lo_x + 1 + longint'($urandom) % (span - 1));
            end
            return t_x'($urandom);
        end
        if (pick < 75) begin
            i = $urandom_range(n - 1, 0);
            return bp_x[i] + t_x'($urandom_range(2)) - t_x'(1);
        end
        return t_x'($urandom);
    endfunction

    function automatic t_count pick_count_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return t_count'($urandom_range(6, 2));
        if (pick < 62) return t_count'($urandom_range(20, 7));
        if (pick < 72) return COUNT_LIMIT;
        if (pick < 78) return t_count'(127);
        if (pick < 84) return t_count'($urandom_range(1, 0));
        if (pick < 90) return t_count'($urandom_range(126, 65));
        return t_count'($urandom_range(63, 21));
    endfunction

    // offer one item, wait for its handshake, record what it should answer
    task automatic send_item(logic [OP_W-1:0] op, t_addr idx, t_x px, t_alpha pa, t_x qx);
        while ($urandom_range(99) < idle_pct) begin
            if (offering) begin
                item_if.valid <= 1'b0;
                offering = 1'b0;
            end
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.operation   <= op;
        item_if.point_index <= idx;
        item_if.point_x     <= px;
        item_if.point_alpha <= pa;
        item_if.query_x     <= qx;
        offering = 1'b1;
        @(posedge i_clk);
        while (!item_if.ready) begin
            @(posedge i_clk);
        end
        awaited_answers.push_back(table_answer(op, idx, px, pa, qx));
        if (op != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        if (offering) begin
            item_if.valid <= 1'b0;
            offering = 1'b0;
        end
        while (awaited_answers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_point_count(t_count value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        count_reg = value;
        @(posedge i_clk);
    endtask

    task automatic set_idle_mode(int send_pct, int recv_pct);
        idle_pct = send_pct;
        stall_pct <= recv_pct;
    endtask

    // fill slots 0..n-1, sorted x except for one shape
    task automatic load_table(int n);
        int     shape;
        int     rise_end;
        int     fall_start;
        longint step_max;
        longint room;
        longint xv;
        t_alpha av;
        t_alpha flat;
        shape    = $urandom_range(5);
        step_max = (longint'(1) << $urandom_range(31, 4)) / n;
        if (step_max < 1) begin
            step_max = 1;
        end
        room       = (longint'(1) << 32) - n * step_max;
        xv         = -(longint'(1) << 31) + longint'($urandom) % room;
        rise_end   = $urandom_range(n - 1, 0);
        fall_start = $urandom_range(n - 1, rise_end);
        flat       = t_alpha'($urandom);
        for (int i = 0; i < n; i++) begin
            case (shape)
                0, 1: begin
                    if (i <= rise_end) begin
                        av = (rise_end == 0) ? ALPHA_ONE : t_alpha'((32768 * i) / rise_end);
                    end else if (i < fall_start) begin
                        av = ALPHA_ONE;
                    end else begin
                        av = t_alpha'((32768 * (n - 1 - i)) / (n - fall_start));
                    end
                end
                2: av = t_alpha'($urandom_range(32768));
                3: av = t_alpha'($urandom);
                4: av = flat;
                default: av = t_alpha'($urandom_range(32768));
            endcase
            if (shape == 5) begin
                send_item(OP_WRITE, t_addr'(i), t_x'($urandom), av, t_x'($urandom));
            end else begin
                send_item(OP_WRITE, t_addr'(i), t_x'(xv), av, t_x'($urandom));
            end
            xv += 1 + longint'($urandom) % step_max;
        end
    endtask

    // unused operation answers zeros and touches nothing
    task automatic test_unused_operation();
        send_item(OP_UNUSED, '1, '1, '1, '1);
        send_item(OP_UNUSED, '0, '0, '0, '0);
    endtask

    // two points at the ends of the x range
    task automatic test_full_span();
        send_item(OP_WRITE, t_addr'(0), t_x'(32'sh8000_0000), '0, '1);
        send_item(OP_WRITE, t_addr'(1), t_x'(32'sh7FFF_FFFF), ALPHA_ONE, '0);
        send_item(OP_EVAL, '1, '1, '1, t_x'(32'sh8000_0000));
        send_item(OP_EVAL, '0, '0, '0, t_x'(32'sh7FFF_FFFF));
        send_item(OP_EVAL, '0, '0, '0, t_x'(32'sh8000_0001));
        send_item(OP_EVAL, '0, '0, '0, t_x'(32'sh7FFF_FFFE));
        send_item(OP_EVAL, '0, '0, '0, t_x'(0));
        send_item(OP_CORE, '1, '1, '1, '1);
    endtask

    // stored alpha above one, output saturates; only a fall, so no bounds
    task automatic test_alpha_above_one();
        send_item(OP_WRITE, t_addr'(0), t_x'(-65536), t_alpha'(16'hFFFF), '0);
        send_item(OP_WRITE, t_addr'(1), t_x'(65536), '0, '0);
        send_item(OP_EVAL, '0, '0, '0, t_x'(-65535));
        send_item(OP_EVAL, '0, '0, '0, t_x'(0));
        send_item(OP_EVAL, '0, '0, '0, t_x'(65535));
        send_item(OP_CORE, '0, '0, '0, '0);
    endtask

    // trapezoid: both core bounds found
    task automatic test_trapezoid_core();
        set_point_count(t_count'(4));
        send_item(OP_WRITE, t_addr'(0), t_x'(-100 * 65536), '0, '0);
        send_item(OP_WRITE, t_addr'(1), t_x'(0), ALPHA_ONE, '0);
        send_item(OP_WRITE, t_addr'(2), t_x'(100 * 65536), ALPHA_ONE, '0);
        send_item(OP_WRITE, t_addr'(3), t_x'(200 * 65536), '0, '0);
        send_item(OP_CORE, '0, '0, '0, '0);
        send_item(OP_EVAL, '0, '0, '0, t_x'(-50 * 65536));
        send_item(OP_EVAL, '0, '0, '0, t_x'(150 * 65536 + 7));
    endtask

    // receiver holds off while the sender keeps offering, then a full drain
    task automatic test_output_backpressure();
        int n;
        wait_drained();
        n = active_points();
        hold_end <= cycle_count + HOLD_CYCLES;
        repeat (24) begin
            if ($urandom_range(1)) begin
                send_item(OP_EVAL, t_addr'($urandom), t_x'($urandom), t_alpha'($urandom),
                          pick_query(n));
            end else begin
                send_item(OP_CORE, t_addr'($urandom), t_x'($urandom), t_alpha'($urandom),
                          t_x'($urandom));
            end
        end
        wait_drained();
    endtask

    // table loads followed by bursts of mixed items
    task automatic test_random_traffic(int budget);
        int     first;
        int     n;
        int     burst;
        int     pick;
        t_addr  slot;
        t_x     px;
        first = items_sent;
        while (items_sent - first < budget) begin
            set_point_count(pick_count_value());
            n = active_points();
            load_table(n);
            burst = $urandom_range(30, 8);
            repeat (burst) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    send_item(OP_EVAL, t_addr'($urandom), t_x'($urandom), t_alpha'($urandom),
                              pick_query(n));
                end else if (pick < 70) begin
                    send_item(OP_CORE, t_addr'($urandom), t_x'($urandom), t_alpha'($urandom),
                              t_x'($urandom));
                end else if (pick < 90) begin
                    slot = t_addr'($urandom);
                    px   = $urandom_range(1) ? bp_x[slot] : t_x'($urandom);
                    send_item(OP_WRITE, slot, px, t_alpha'($urandom_range(32768)),
                              t_x'($urandom));
                end else begin
                    send_item(OP_UNUSED, t_addr'($urandom), t_x'($urandom), t_alpha'($urandom),
                              t_x'($urandom));
                end
            end
        end
    endtask

    // result checker, receiver stalls and cycle limit
    initial begin : result_monitor
        answer_t seen;
        answer_t want;
        result_if.ready = 1'b0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
            if (i_rst_n && result_if.valid && result_if.ready) begin
                seen.membership       = result_if.membership;
                seen.core_lower       = result_if.core_lower;
                seen.core_lower_valid = result_if.core_lower_valid;
                seen.core_upper       = result_if.core_upper;
                seen.core_upper_valid = result_if.core_upper_valid;
                if (awaited_answers.size() == 0) begin
                    report_error($sformatf("unexpected result at cycle %0d", cycle_count));
                end else begin
                    want = awaited_answers.pop_front();
                    if (seen !== want) begin
                        report_error($sformatf(
                            {"mismatch at cycle %0d: expected mem %0d lo %0d/%0b up %0d/%0b,",
                             " got mem %0d lo %0d/%0b up %0d/%0b"},
                            cycle_count, want.membership, $signed(want.core_lower),
                            want.core_lower_valid, $signed(want.core_upper),
                            want.core_upper_valid, seen.membership, $signed(seen.core_lower),
                            seen.core_lower_valid, $signed(seen.core_upper),
                            seen.core_upper_valid));
                    end
                end
            end
            result_if.ready <= (cycle_count < hold_end) ? 1'b0 : ($urandom_range(99) >= stall_pct);
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        item_if.valid       = 1'b0;
        item_if.operation   = '0;
        item_if.point_index = '0;
        item_if.point_x     = '0;
        item_if.point_alpha = '0;
        item_if.query_x     = '0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        i_rst_n             = 1'b0;
        count_reg           = COUNT_RESET;
        for (int i = 0; i < MAX_POINTS; i++) begin
            bp_x[i]     = '0;
            bp_alpha[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unused_operation();
        test_full_span();
        test_alpha_above_one();
        test_trapezoid_core();
        test_output_backpressure();

        set_idle_mode(0, 0);
        test_random_traffic(500);
        set_idle_mode(53, 0);
        test_random_traffic(500);
        set_idle_mode(0, 53);
        test_random_traffic(500);
        set_idle_mode(12, 12);
        test_random_traffic(500);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_answers.size() != 0) begin
            report_error($sformatf("%0d results never arrived", awaited_answers.size()));
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
